### hw/rtl/mhpq_pkg.sv
// Shared types and constants for the min-heap priority queue.
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 8;
    localparam int STAT_W = 2;

    localparam logic [CNT_W-1:0]  CAP_RESET   = 8'd128;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;

    localparam logic              MODE_INSERT = 1'b0;
    localparam logic              MODE_DELETE = 1'b1;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_INS  = 2'd1,
        OP_DEL  = 2'd2
    } t_op;

    // broadcast from the controller to every cell
    typedef struct packed {
        t_op                      op;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

    // what a cell shows its neighbors
    typedef struct packed {
        logic                     vld;
        logic signed [DATA_W-1:0] val;
        logic                     gt;   // insert value goes before this cell
    } t_cell_data;

endpackage

### hw/rtl/mhpq_cell.sv
// One cell of the sorted systolic array: holds a single element.
`timescale 1ns / 1ps

module mhpq_cell
    import mhpq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  t_cell_data i_prev,
    input  t_cell_data i_next,
    output t_cell_data o_data
);

    logic                     r_vld;
    logic                     n_vld;
    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;
    logic                     gt;

    // empty cells count as greater than anything
    assign gt = !r_vld || (i_ctl.value < r_val);

    assign o_data.vld = r_vld;
    assign o_data.val = r_val;
    assign o_data.gt  = gt;

    always_comb begin
        n_vld = r_vld;
        n_val = r_val;
        case (i_ctl.op)
            OP_INS: begin
                if (gt) begin
                    n_val = i_prev.gt ? i_prev.val : i_ctl.value;
                    n_vld = r_vld | i_prev.vld;
                end
            end
            OP_DEL: begin
                n_val = i_next.val;
                n_vld = i_next.vld;
            end
            default: begin
                n_vld = r_vld;
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

### hw/rtl/min_heap_priority_queue_core.sv
// Priority queue top level: controller plus a sorted chain of element cells.
// The result strobe o_done is registered and comes in the cycle after a request is taken.
// Throughput: one request per cycle; every cell compares against the broadcast
// value and shifts with its neighbor in that same cycle, so busy stays low.
// Reset (synchronous, active low) empties the queue and sets capacity to 128.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module min_heap_priority_queue_core
    import mhpq_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_mode,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CNT_W-1:0]         i_cfg_capacity,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_min_value,
    output logic [STAT_W-1:0]        o_status,
    output logic [CNT_W-1:0]         o_occupancy
);

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [CNT_W-1:0]         r_cap;
    logic                     r_done;
    logic signed [DATA_W-1:0] r_min;
    logic signed [DATA_W-1:0] n_min;
    logic [STAT_W-1:0]        r_status;
    logic [STAT_W-1:0]        n_status;

    logic                     accept;
    logic                     full;
    t_cell_ctl                ctl;
    t_cell_data               cell_q [DEPTH];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // limit is the smaller of capacity and the number of cells
    assign full = (r_count >= r_cap) || (32'(r_count) >= DEPTH);

    always_comb begin
        n_count    = r_count;
        n_min      = '0;
        n_status   = STAT_OK;
        ctl.op     = OP_NONE;
        ctl.value  = i_value;
        if (accept) begin
            case (i_mode)
                MODE_INSERT: begin
                    if (full) begin
                        n_status = STAT_FULL;
                    end else begin
                        ctl.op  = OP_INS;
                        n_count = r_count + 1'b1;
                    end
                end
                MODE_DELETE: begin
                    if (r_count == '0) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        ctl.op  = OP_DEL;
                        n_min   = cell_q[0].val;
                        n_count = r_count - 1'b1;
                    end
                end
                default: begin
                    n_status = STAT_OK;
                end
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_cell_data prev_d;
            t_cell_data next_d;
            if (g == 0) begin : g_head
                assign prev_d = '{vld: 1'b1, val: '0, gt: 1'b0};
            end else begin : g_mid_prev
                assign prev_d = cell_q[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign next_d = '{vld: 1'b0, val: '0, gt: 1'b0};
            end else begin : g_mid_next
                assign next_d = cell_q[g+1];
            end
            mhpq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (ctl),
                .i_prev  (prev_d),
                .i_next  (next_d),
                .o_data  (cell_q[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= CAP_RESET;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= accept;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_capacity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_min    <= n_min;
        r_status <= n_status;
    end

    assign o_done      = r_done;
    assign o_min_value = r_min;
    assign o_status    = r_status;
    assign o_occupancy = r_count;

    a_head_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_q[0].vld == (r_count != '0))
        else $error("head cell valid disagrees with count");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_q[1 % DEPTH].vld && (DEPTH > 1) |-> cell_q[0].val <= cell_q[1 % DEPTH].val)
        else $error("first two cells out of order");

    a_fail_zero_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status != STAT_OK) |-> (o_min_value == '0))
        else $error("failed request returned a nonzero minimum");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (ctl.op == OP_NONE) |=> $stable(r_count))
        else $error("count moved on a dropped request");

endmodule
